// File: hw/rtl/dgpg_pkg.sv
// ----------------------------------------------------------------------------
// dgpg_pkg
// Types, constants and the fraction table shared by the delayed gate pulse
// generator modules.
// ----------------------------------------------------------------------------
package dgpg_pkg;

	// Field widths
	localparam int CTL_BITS       = 9;
	localparam int LEVEL_BITS     = 17;
	localparam int MS_BITS        = 10;
	localparam int SPS_BITS       = 20;
	localparam int STEP_BITS      = 17;
	localparam int FRAC_BITS      = 16;
	localparam int FRAC_ROWS      = 12;
	localparam int FRAC_IDX_BITS  = 4;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 20;

	localparam logic [CTL_BITS-1:0]   CTL_FULL  = 9'd256;
	localparam logic [LEVEL_BITS-1:0] LEVEL_ONE = 17'd65536;

	// Configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SAMPLES_PER_MS  = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SAMPLES_PER_SEC = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_RANGE_LONG      = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_REPEAT_MODE     = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_RETRIGGER_MODE  = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SLEW_STEP       = 3'd5;

	// Reset values of the configuration registers
	localparam logic [MS_BITS-1:0]   MS_RESET   = 10'd48;
	localparam logic [SPS_BITS-1:0]  SPS_RESET  = 20'd48000;
	localparam logic [STEP_BITS-1:0] STEP_RESET = 17'd65536;

	typedef struct packed {
		logic                trig_edge;
		logic                clock_edge;
		logic                clock_present;
		logic [CTL_BITS-1:0] delay_ctl;
		logic [CTL_BITS-1:0] length_ctl;
		logic [CTL_BITS-1:0] amp_ctl;
	} in_item_t;

	typedef struct packed {
		logic                  clock_pulse;
		logic                  eoc_pulse;
		logic [LEVEL_BITS-1:0] gate_level;
		logic                  gate_phase;
	} out_item_t;

	// Operand select of the shared multiplier
	typedef enum logic [1:0] {
		MUL_DELAY = 2'd0,
		MUL_GATE  = 2'd1,
		MUL_AMP   = 2'd2
	} mul_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic     accept;
		mul_sel_t mul_sel;
		logic     load_delay_tgt;
		logic     load_gate_tgt;
		logic     update;
		logic     load_out;
	} dgpg_cmd_t;

	// Q16 fractions of the clock period
	function automatic logic [FRAC_BITS-1:0] frac_entry(input logic [FRAC_IDX_BITS-1:0] row);
		logic [FRAC_BITS-1:0] f;
		unique case (row)
			4'd0:    f = 16'd256;
			4'd1:    f = 16'd512;
			4'd2:    f = 16'd1024;
			4'd3:    f = 16'd2048;
			4'd4:    f = 16'd4096;
			4'd5:    f = 16'd8192;
			4'd6:    f = 16'd12288;
			4'd7:    f = 16'd16384;
			4'd8:    f = 16'd21845;
			4'd9:    f = 16'd32768;
			4'd10:   f = 16'd49152;
			default: f = 16'd64881;
		endcase
		return f;
	endfunction

endpackage

// File: hw/rtl/dgpg_ctrl.sv
// ----------------------------------------------------------------------------
// dgpg_ctrl
// Sequencer for one tick: delay multiply, gate multiply, gate target,
// state update, amplitude multiply into the output register.
// ----------------------------------------------------------------------------
module dgpg_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	output logic                 result_valid,
	input  logic                 result_ready,
	output dgpg_pkg::dgpg_cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_GATE_MUL = 5'b00010,
		ST_GATE_TGT = 5'b00100,
		ST_UPDATE   = 5'b01000,
		ST_AMP      = 5'b10000
	} state_t;

	state_t state_q, state_nx;
	logic   result_valid_q;

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;

	// Command decode
	always_comb begin
		cmd                = '0;
		cmd.mul_sel        = dgpg_pkg::MUL_DELAY;
		cmd.accept         = item_valid && (state_q == ST_IDLE);
		cmd.load_delay_tgt = (state_q == ST_GATE_MUL);
		cmd.load_gate_tgt  = (state_q == ST_GATE_TGT);
		cmd.update         = (state_q == ST_UPDATE);
		cmd.load_out       = (state_q == ST_AMP) && (!result_valid_q || result_ready);
		unique case (state_q)
			ST_GATE_MUL: cmd.mul_sel = dgpg_pkg::MUL_GATE;
			ST_AMP:      cmd.mul_sel = dgpg_pkg::MUL_AMP;
			default:     cmd.mul_sel = dgpg_pkg::MUL_DELAY;
		endcase
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:     if (cmd.accept) state_nx = ST_GATE_MUL;
			ST_GATE_MUL: state_nx = ST_GATE_TGT;
			ST_GATE_TGT: state_nx = ST_UPDATE;
			ST_UPDATE:   state_nx = ST_AMP;
			ST_AMP:      if (cmd.load_out) state_nx = ST_IDLE;
			default:     state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// An accepted item always starts the gate multiply next
	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == ST_GATE_MUL))
		else $error("accepted item did not start the sequence");

	// The output register is only loaded when it is empty or draining
	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!result_valid_q || result_ready))
		else $error("result overwritten before transfer");

	// A stalled result keeps the sequencer parked with valid high
	a_amp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AMP && !cmd.load_out) |=> (state_q == ST_AMP && result_valid_q))
		else $error("sequencer left the output step without loading");

endmodule

// File: hw/rtl/dgpg_datapath.sv
// ----------------------------------------------------------------------------
// dgpg_datapath
// Configuration registers, phase counters, clock period meter, slew level,
// pulse timers, one shared multiplier and the output register.
// ----------------------------------------------------------------------------
module dgpg_datapath #(
	parameter int COUNT_BITS    = 24,
	parameter int TABLE_ENTRIES = 12
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  dgpg_pkg::dgpg_cmd_t                     cmd,
	input  dgpg_pkg::in_item_t                      item,
	input  logic                                    cfg_we,
	input  logic [dgpg_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [dgpg_pkg::CFG_DATA_BITS-1:0]      cfg_data,
	output dgpg_pkg::out_item_t                     result
);

	localparam int MA      = (COUNT_BITS > dgpg_pkg::SPS_BITS) ? COUNT_BITS : dgpg_pkg::SPS_BITS;
	localparam int PW      = MA + dgpg_pkg::FRAC_BITS;
	localparam int LW      = PW + 5;
	localparam int TI_BITS = $clog2(TABLE_ENTRIES);
	localparam int TP_BITS = TI_BITS + dgpg_pkg::CTL_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// Configuration registers
	logic [dgpg_pkg::MS_BITS-1:0]   ms_q;
	logic [dgpg_pkg::SPS_BITS-1:0]  sps_q;
	logic                           range_q, repeat_q, retrig_q;
	logic [dgpg_pkg::STEP_BITS-1:0] step_q;

	// Latched item fields
	logic                          trig_q, clk_q, present_q;
	logic [dgpg_pkg::CTL_BITS-1:0] lctl_q, actl_q;

	// Block state
	logic [COUNT_BITS-1:0]           delay_count_q, gate_count_q, clock_count_q, clock_period_q;
	logic                            delay_active_q, gate_active_q;
	logic [dgpg_pkg::LEVEL_BITS-1:0] level_q;
	logic [dgpg_pkg::MS_BITS-1:0]    cp_left_q, eoc_left_q;
	logic                            cp_bit_q, eoc_bit_q, phase_q;

	// Multiplier and targets
	logic [MA-1:0]                  mul_a;
	logic [dgpg_pkg::FRAC_BITS-1:0] mul_b;
	logic [PW-1:0]                  mul_p, prod_q;
	logic [COUNT_BITS-1:0]          delay_tgt_q, gate_tgt_q, period_eff;

	// Update step
	logic [COUNT_BITS-1:0]           nx_dc, nx_gc;
	logic                            nx_d, nx_g, was_gate, eoc_fire;
	logic [dgpg_pkg::LEVEL_BITS:0]   lv_sum;
	logic [dgpg_pkg::LEVEL_BITS-1:0] nx_level;
	logic [dgpg_pkg::MS_BITS-1:0]    cp_arm, eoc_arm;

	function automatic logic [dgpg_pkg::CTL_BITS-1:0] clamp_ctl(
		input logic [dgpg_pkg::CTL_BITS-1:0] v);
		return (v > dgpg_pkg::CTL_FULL) ? dgpg_pkg::CTL_FULL : v;
	endfunction

	// Table row from a control: floor((entries - 1) * ctl / 256), capped at the last row
	function automatic logic [dgpg_pkg::FRAC_BITS-1:0] ctl_frac(
		input logic [dgpg_pkg::CTL_BITS-1:0] ctl);
		logic [TP_BITS-1:0]                  p;
		logic [TI_BITS-1:0]                  idx;
		logic [dgpg_pkg::FRAC_IDX_BITS-1:0]  row;
		p   = TP_BITS'(TABLE_ENTRIES - 1) * TP_BITS'(ctl);
		idx = TI_BITS'(p >> 8);
		if (int'(idx) >= dgpg_pkg::FRAC_ROWS) begin
			row = dgpg_pkg::FRAC_IDX_BITS'(dgpg_pkg::FRAC_ROWS - 1);
		end else begin
			row = dgpg_pkg::FRAC_IDX_BITS'(idx);
		end
		return dgpg_pkg::frac_entry(row);
	endfunction

	// Phase length from a product: clock mode takes the Q16 fraction, free mode
	// scales by one or ten and drops the Q8 point; saturates at the count width
	function automatic logic [COUNT_BITS-1:0] length_of(
		input logic [PW-1:0]                prod,
		input logic                         clock_mode,
		input logic                         long_range,
		input logic                         add_ms,
		input logic [dgpg_pkg::MS_BITS-1:0] ms);
		logic [LW-1:0] scaled;
		logic [LW-1:0] t;
		if (clock_mode) begin
			t = LW'(prod >> dgpg_pkg::FRAC_BITS);
		end else begin
			scaled = long_range ? ((LW'(prod) << 3) + (LW'(prod) << 1)) : LW'(prod);
			t      = scaled >> 8;
			if (add_ms) t = t + LW'(ms);
		end
		if (t > LW'(COUNT_MAX)) t = LW'(COUNT_MAX);
		if (clock_mode && add_ms && (t < LW'(ms))) t = LW'(ms);
		return COUNT_BITS'(t);
	endfunction

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q     <= dgpg_pkg::MS_RESET;
			sps_q    <= dgpg_pkg::SPS_RESET;
			range_q  <= 1'b0;
			repeat_q <= 1'b0;
			retrig_q <= 1'b0;
			step_q   <= dgpg_pkg::STEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dgpg_pkg::CFG_SAMPLES_PER_MS:  ms_q     <= cfg_data[dgpg_pkg::MS_BITS-1:0];
				dgpg_pkg::CFG_SAMPLES_PER_SEC: sps_q    <= cfg_data[dgpg_pkg::SPS_BITS-1:0];
				dgpg_pkg::CFG_RANGE_LONG:      range_q  <= cfg_data[0];
				dgpg_pkg::CFG_REPEAT_MODE:     repeat_q <= cfg_data[0];
				dgpg_pkg::CFG_RETRIGGER_MODE:  retrig_q <= cfg_data[0];
				dgpg_pkg::CFG_SLEW_STEP:       step_q   <= cfg_data[dgpg_pkg::STEP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Period source for the delay multiply: a clock edge this tick latches the running count
	assign period_eff = item.clock_edge ? clock_count_q : clock_period_q;

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			dgpg_pkg::MUL_DELAY: begin
				if (item.clock_present) begin
					mul_a = MA'(period_eff);
					mul_b = ctl_frac(clamp_ctl(item.delay_ctl));
				end else begin
					mul_a = MA'(sps_q);
					mul_b = dgpg_pkg::FRAC_BITS'(clamp_ctl(item.delay_ctl));
				end
			end
			dgpg_pkg::MUL_GATE: begin
				if (present_q) begin
					mul_a = MA'(clock_period_q);
					mul_b = ctl_frac(lctl_q);
				end else begin
					mul_a = MA'(sps_q);
					mul_b = dgpg_pkg::FRAC_BITS'(lctl_q);
				end
			end
			dgpg_pkg::MUL_AMP: begin
				mul_a = MA'(level_q);
				mul_b = dgpg_pkg::FRAC_BITS'(actl_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = PW'(mul_a) * PW'(mul_b);

	// Product and phase targets
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (cmd.load_delay_tgt) delay_tgt_q <= length_of(prod_q, present_q, range_q, 1'b0, ms_q);
		if (cmd.load_gate_tgt)  gate_tgt_q  <= length_of(prod_q, present_q, range_q, 1'b1, ms_q);
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			trig_q    <= item.trig_edge;
			clk_q     <= item.clock_edge;
			present_q <= item.clock_present;
			lctl_q    <= clamp_ctl(item.length_ctl);
			actl_q    <= clamp_ctl(item.amp_ctl);
		end
	end

	// Phase sequencing, slew and pulse timers for one tick
	always_comb begin
		nx_d     = delay_active_q;
		nx_g     = gate_active_q;
		nx_dc    = delay_count_q;
		nx_gc    = gate_count_q;
		eoc_fire = 1'b0;
		if ((trig_q || clk_q) && (retrig_q || (!gate_active_q && !delay_active_q))) begin
			nx_dc = '0;
			nx_d  = 1'b1;
			nx_g  = 1'b0;
		end
		if (nx_d) begin
			if (nx_dc < delay_tgt_q) begin
				nx_dc = nx_dc + COUNT_BITS'(1);
			end else begin
				nx_d  = 1'b0;
				nx_g  = 1'b1;
				nx_gc = '0;
			end
		end
		was_gate = nx_g;
		if (nx_g) begin
			if (nx_gc < gate_tgt_q) begin
				nx_gc = nx_gc + COUNT_BITS'(1);
			end else begin
				eoc_fire = 1'b1;
				nx_g     = 1'b0;
				if (repeat_q) begin
					nx_dc = '0;
					nx_d  = 1'b1;
				end
			end
		end

		// Level slews toward one during the gate, toward zero otherwise
		lv_sum = {1'b0, level_q} + {1'b0, step_q};
		if (was_gate) begin
			if (level_q < dgpg_pkg::LEVEL_ONE) begin
				nx_level = (lv_sum > {1'b0, dgpg_pkg::LEVEL_ONE}) ?
					dgpg_pkg::LEVEL_ONE : lv_sum[dgpg_pkg::LEVEL_BITS-1:0];
			end else begin
				nx_level = dgpg_pkg::LEVEL_ONE;
			end
		end else begin
			nx_level = (level_q > step_q) ? (level_q - step_q) : '0;
		end

		// A new pulse restarts at the longer of what is left and one millisecond
		cp_arm  = (clk_q && (ms_q > cp_left_q)) ? ms_q : cp_left_q;
		eoc_arm = (eoc_fire && (ms_q > eoc_left_q)) ? ms_q : eoc_left_q;
	end

	// Block state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_count_q  <= '0;
			gate_count_q   <= '0;
			clock_count_q  <= '0;
			clock_period_q <= '0;
			delay_active_q <= 1'b0;
			gate_active_q  <= 1'b0;
			level_q        <= '0;
			cp_left_q      <= '0;
			eoc_left_q     <= '0;
		end else begin
			// clock period meter runs at acceptance
			if (cmd.accept) begin
				if (item.clock_edge) clock_period_q <= clock_count_q;
				if (item.clock_present) begin
					if (item.clock_edge) begin
						clock_count_q <= COUNT_BITS'(1);
					end else if (clock_count_q != COUNT_MAX) begin
						clock_count_q <= clock_count_q + COUNT_BITS'(1);
					end
				end else if (item.clock_edge) begin
					clock_count_q <= '0;
				end
			end
			if (cmd.update) begin
				delay_count_q  <= nx_dc;
				gate_count_q   <= nx_gc;
				delay_active_q <= nx_d;
				gate_active_q  <= nx_g;
				level_q        <= nx_level;
				cp_left_q      <= (cp_arm != '0) ? (cp_arm - dgpg_pkg::MS_BITS'(1)) : cp_arm;
				eoc_left_q     <= (eoc_arm != '0) ? (eoc_arm - dgpg_pkg::MS_BITS'(1)) : eoc_arm;
			end
		end
	end

	// Per-tick result bits
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			cp_bit_q  <= (cp_arm != '0);
			eoc_bit_q <= (eoc_arm != '0);
			phase_q   <= nx_g;
		end
	end

	// Output register, fed straight from the amplitude multiply
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result.clock_pulse <= cp_bit_q;
			result.eoc_pulse   <= eoc_bit_q;
			result.gate_level  <= dgpg_pkg::LEVEL_BITS'(mul_p >> 8);
			result.gate_phase  <= phase_q;
		end
	end

	// Delay and gate phases never run together
	a_phase_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(delay_active_q && gate_active_q))
		else $error("delay and gate phases both active");

	// Slewed level stays within zero to one
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= dgpg_pkg::LEVEL_ONE)
		else $error("gate level above full scale");

	// Level only moves on the update step
	a_level_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.update |=> $stable(level_q))
		else $error("gate level changed outside the update step");

endmodule

// File: hw/rtl/delayed_gate_pulse_generator_top.sv
// ----------------------------------------------------------------------------
// delayed_gate_pulse_generator_top
// Delay / gate / end-of-cycle generator with clock-relative or free timing.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: one transfer per sample tick, carrying qualified trigger and
//   clock edges, the clock-present flag and the Q8 delay, length and
//   amplitude controls.
//   result channel: one transfer per item with the clock and end-of-cycle
//   pulses, the slewed and amplitude-scaled Q16 gate level and the gate phase.
//   cfg channel: register writes, always ready; write only while no item is
//   in flight.
//   Each tick makes three passes through one shared multiplier (delay length,
//   gate length, amplitude) plus a target step and a state update step, and
//   the result is registered from the amplitude pass; the next item is taken
//   only after that, so items do not overlap.
//   The next item is taken while a finished result waits in the output
//   register; a stalled receiver holds the block in its output step after
//   that, so at most one result waits.
//   Reset clears all counters, phases, level and pulse timers and loads the
//   register defaults: 48 ticks/ms, 48000 ticks/s, instant slew.
// ----------------------------------------------------------------------------
module delayed_gate_pulse_generator_top #(
	parameter int COUNT_BITS    = 24,
	parameter int TABLE_ENTRIES = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  dgpg_pkg::in_item_t                   item,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output dgpg_pkg::out_item_t                  result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dgpg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [dgpg_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	dgpg_pkg::dgpg_cmd_t cmd;

	// Register writes are always accepted and land in the next cycle
	assign cfg_ready = 1'b1;

	dgpg_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd)
	);

	dgpg_datapath #(
		.COUNT_BITS    (COUNT_BITS),
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item      (item),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

endmodule
